FILE: rtl/kmld_pkg.sv
// Shared types and constants for the key matrix lockout debounce block.
package kmld_pkg;

    localparam int ROW_W = 3;
    localparam int COL_W = 4;
    localparam int TIME_W = 32;
    localparam int WINDOW_W = 16;
    localparam int CALC_W = 10;

    localparam int KEY_ROWS_DEFAULT = 8;
    localparam int KEY_COLUMNS_DEFAULT = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WINDOW_W-1:0] LOCKOUT_RESET_MS = 16'd50;

    typedef struct packed {
        logic [ROW_W-1:0]  key_row;
        logic [COL_W-1:0]  key_column;
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } in_req_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_column;
        logic             debounced_level;
        logic             press_event;
        logic             release_event;
    } out_req_t;

endpackage

FILE: rtl/kmld_front.sv
// Front stage: accepts samples, drops keys outside the matrix and computes the key index.
module kmld_front #(
    parameter int KEY_ROWS = kmld_pkg::KEY_ROWS_DEFAULT,
    parameter int KEY_COLUMNS = kmld_pkg::KEY_COLUMNS_DEFAULT,
    parameter int IDX_W = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  kmld_pkg::in_req_t                      in_request,
    input  logic                                   clear_busy,
    input  logic                                   queue_full,
    output logic                                   push,
    output logic [IDX_W+$bits(kmld_pkg::in_req_t)-1:0] push_data
);

    localparam logic [4:0] ROWS_L = 5'(KEY_ROWS);
    localparam logic [5:0] COLUMNS_L = 6'(KEY_COLUMNS);
    localparam logic [kmld_pkg::CALC_W-1:0] COLUMNS_C = kmld_pkg::CALC_W'(KEY_COLUMNS);

    logic              valid_reg;
    logic              valid_next;
    logic [IDX_W-1:0]  idx_reg;
    kmld_pkg::in_req_t req_reg;

    logic                        take;
    logic                        in_range;
    logic [kmld_pkg::CALC_W-1:0] flat_index;

    assign in_stall = clear_busy | (valid_reg & queue_full);
    assign take = in_valid & ~in_stall;

    assign in_range = ({2'b00, in_request.key_row} < ROWS_L)
                    && ({2'b00, in_request.key_column} < COLUMNS_L);

    assign flat_index = kmld_pkg::CALC_W'(in_request.key_row) * COLUMNS_C
                      + kmld_pkg::CALC_W'(in_request.key_column);

    assign push = valid_reg & ~queue_full;
    assign push_data = {idx_reg, req_reg};

    always_comb
    begin
        valid_next = valid_reg & ~push;
        if (take && in_range)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_range)
        begin
            idx_reg <= IDX_W'(flat_index);
            req_reg <= in_request;
        end
    end

endmodule

FILE: rtl/kmld_queue.sv
// Short first-in first-out queue between the front stage and the back stage.
module kmld_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kmld_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head_data = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full = (count_reg == DEPTH_C);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/kmld_back.sv
// Back stage: per-key state memory, debounce update with forwarding, and the result register.
module kmld_back #(
    parameter int KEY_ROWS = kmld_pkg::KEY_ROWS_DEFAULT,
    parameter int KEY_COLUMNS = kmld_pkg::KEY_COLUMNS_DEFAULT,
    parameter int IDX_W = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [kmld_pkg::WINDOW_W-1:0]          cfg_write_data,
    input  logic [IDX_W+$bits(kmld_pkg::in_req_t)-1:0] head_data,
    input  logic                                   queue_not_empty,
    output logic                                   pop,
    output logic                                   clear_busy,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output kmld_pkg::out_req_t                     out_request
);

    localparam int KEY_COUNT = KEY_ROWS * KEY_COLUMNS;
    localparam logic [IDX_W-1:0] LAST_KEY = IDX_W'(KEY_COUNT - 1);

    typedef struct packed {
        logic                        level;
        logic                        pending;
        logic [kmld_pkg::TIME_W-1:0] start_ms;
    } key_state_t;

    key_state_t state_mem [KEY_COUNT];

    logic [kmld_pkg::WINDOW_W-1:0] lockout_reg;
    logic                          clear_busy_reg;
    logic [IDX_W-1:0]              clear_idx_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [IDX_W-1:0]  s1_idx_reg;
    kmld_pkg::in_req_t s1_req_reg;
    key_state_t        rdata_reg;

    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_idx_reg;
    key_state_t       fwd_data_reg;

    logic               out_valid_reg;
    kmld_pkg::out_req_t out_reg;

    logic                        out_free;
    logic                        s1_done;
    logic                        s1_load;
    logic [IDX_W-1:0]            head_idx;
    kmld_pkg::in_req_t           head_req;
    key_state_t                  cur;
    key_state_t                  nxt;
    logic [kmld_pkg::TIME_W-1:0] elapsed;
    logic                        in_window;
    logic                        take_change;
    logic                        press;
    logic                        release_flag;
    logic                        has_result;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    key_state_t                  wr_data;

    assign head_idx = head_data[IDX_W+$bits(kmld_pkg::in_req_t)-1:$bits(kmld_pkg::in_req_t)];
    assign head_req = head_data[$bits(kmld_pkg::in_req_t)-1:0];

    assign clear_busy = clear_busy_reg;
    assign out_valid = out_valid_reg;
    assign out_request = out_reg;

    assign cur = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_data_reg : rdata_reg;
    assign elapsed = s1_req_reg.now_ms - cur.start_ms;
    assign in_window = elapsed < {{(kmld_pkg::TIME_W - kmld_pkg::WINDOW_W){1'b0}}, lockout_reg};

    always_comb
    begin
        nxt = cur;
        take_change = 1'b0;
        press = 1'b0;
        release_flag = 1'b0;
        if (s1_req_reg.raw_level != cur.level)
        begin
            if (!cur.pending)
            begin
                take_change = 1'b1;
                nxt.pending = 1'b1;
                nxt.start_ms = s1_req_reg.now_ms;
            end
            else if (!in_window)
            begin
                take_change = 1'b1;
                nxt.pending = 1'b0;
            end
        end
        if (take_change)
        begin
            press = ~cur.level;
            release_flag = cur.level;
            nxt.level = s1_req_reg.raw_level;
        end
    end

    assign has_result = nxt.level | press | release_flag;
    assign out_free = ~out_valid_reg | ~out_stall;
    assign s1_done = s1_valid_reg & (~has_result | out_free);
    assign s1_load = queue_not_empty & ~clear_busy_reg & (~s1_valid_reg | s1_done);
    assign pop = s1_load;

    assign s1_valid_next = s1_load | (s1_valid_reg & ~s1_done);

    assign wr_en = clear_busy_reg | s1_done;
    assign wr_addr = clear_busy_reg ? clear_idx_reg : s1_idx_reg;
    assign wr_data = clear_busy_reg ? key_state_t'('0) : nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= kmld_pkg::LOCKOUT_RESET_MS;
            clear_busy_reg <= 1'b1;
            clear_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                lockout_reg <= cfg_write_data;
            end
            if (clear_busy_reg)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
                if (clear_idx_reg == LAST_KEY)
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
            s1_valid_reg <= s1_valid_next;
            if (s1_done)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_done && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_idx_reg <= head_idx;
            s1_req_reg <= head_req;
        end
        if (s1_done)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_data_reg <= nxt;
        end
        if (s1_done && has_result)
        begin
            out_reg.out_row <= s1_req_reg.key_row;
            out_reg.out_column <= s1_req_reg.key_column;
            out_reg.debounced_level <= nxt.level;
            out_reg.press_event <= press;
            out_reg.release_event <= release_flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_data;
        end
        if (s1_load)
        begin
            rdata_reg <= state_mem[head_idx];
        end
    end

endmodule

FILE: rtl/key_matrix_lockout_debounce.sv
// Top level of the key matrix debounce block with a per-key lockout window.
//
// Samples enter on in_valid/in_stall with in_request; results leave on
// out_valid/out_stall with out_request. A request is taken at a rising edge
// where valid is high and stall is low. A sample for a key outside the matrix
// is taken and dropped. A result is sent only when the key's accepted level is
// closed or the sample caused a press or a release.
// The block takes one sample per cycle while in_stall is low, limited by the
// single read and single write port of the per-key state memory; back-to-back
// samples of one key are served by forwarding the last written state. A sample
// passes the front register, queue, state read stage and result register.
// After reset the block clears its state memory, one key per cycle, for all
// KEY_ROWS * KEY_COLUMNS keys, and holds in_stall high meanwhile. The lockout
// window resets to 50 ms. The user writes it through cfg_write_en and
// cfg_write_data only while the block is idle; the block does not enforce this.
// On a receiver stall the result register holds its request, a two entry queue
// behind the front stage fills, and in_stall rises once both are full.
module key_matrix_lockout_debounce #(
    parameter int KEY_ROWS = kmld_pkg::KEY_ROWS_DEFAULT,
    parameter int KEY_COLUMNS = kmld_pkg::KEY_COLUMNS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [kmld_pkg::WINDOW_W-1:0] cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  kmld_pkg::in_req_t             in_request,
    output logic                          out_valid,
    input  logic                          out_stall,
    output kmld_pkg::out_req_t            out_request
);

    localparam int KEY_COUNT = KEY_ROWS * KEY_COLUMNS;
    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int ENTRY_W = IDX_W + $bits(kmld_pkg::in_req_t);

    logic               clear_busy;
    logic               queue_full;
    logic               queue_not_empty;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] head_data;

    kmld_front #(
        .KEY_ROWS    (KEY_ROWS),
        .KEY_COLUMNS (KEY_COLUMNS),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_request (in_request),
        .clear_busy (clear_busy),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    kmld_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (kmld_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    kmld_back #(
        .KEY_ROWS    (KEY_ROWS),
        .KEY_COLUMNS (KEY_COLUMNS),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .head_data       (head_data),
        .queue_not_empty (queue_not_empty),
        .pop             (pop),
        .clear_busy      (clear_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_request     (out_request)
    );

endmodule

FILE: bench/key_matrix_lockout_debounce_tb.sv
// Self-checking testbench for the key matrix lockout debounce block.
`timescale 1ns / 100ps

module key_matrix_lockout_debounce_tb;

    import kmld_pkg::*;

    localparam int KEY_ROWS = KEY_ROWS_DEFAULT;
    localparam int KEY_COLS = KEY_COLUMNS_DEFAULT;
    localparam int KEY_COUNT = KEY_ROWS * KEY_COLS;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_SAMPLES = 150;

    typedef struct {
        bit                  set_win;
        logic [WINDOW_W-1:0] win;
        in_req_t             smp;
        bit                  pinned;
        bit                  pin_has;
        out_req_t            pin_res;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_en;
    logic [WINDOW_W-1:0] cfg_write_data;
    logic                in_valid;
    logic                in_stall;
    in_req_t             in_request;
    logic                out_valid;
    logic                out_stall;
    out_req_t            out_request;

    bit                  key_level [KEY_COUNT];
    bit                  key_pending [KEY_COUNT];
    logic [TIME_W-1:0]   key_start [KEY_COUNT];
    logic [WINDOW_W-1:0] lockout_ms;

    out_req_t            expected_reports [$];
    step_t               directed_steps [$];
    int                  report_errors = 0;
    int                  hold_cycles = 0;
    bit                  sink_stalls = 1'b0;
    int unsigned         focus_keys [4];
    logic [TIME_W-1:0]   scan_clock_ms;

    key_matrix_lockout_debounce dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_request     (in_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_request    (out_request)
    );

    always #5 clk = ~clk;

    function automatic bit predict_debounce(input in_req_t smp, output out_req_t res);
        int unsigned       k;
        logic [TIME_W-1:0] elapsed;
        bit                lvl;
        bit                press;
        bit                rel;
        bit                take;
        press = 1'b0;
        rel = 1'b0;
        res = '0;
        if (smp.key_row >= KEY_ROWS || smp.key_column >= KEY_COLS)
            return 1'b0;
        k = smp.key_row * KEY_COLS + smp.key_column;
        lvl = key_level[k];
        if (smp.raw_level != lvl)
        begin
            elapsed = smp.now_ms - key_start[k];
            if (!key_pending[k])
            begin
                take = 1'b1;
                key_pending[k] = 1'b1;
                key_start[k] = smp.now_ms;
            end
            else if (elapsed < {16'd0, lockout_ms})
            begin
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
                key_pending[k] = 1'b0;
            end
            if (take)
            begin
                rel = lvl;
                press = !lvl;
                lvl = smp.raw_level;
                key_level[k] = lvl;
            end
        end
        res.out_row = smp.key_row;
        res.out_column = smp.key_column;
        res.debounced_level = lvl;
        res.press_event = press;
        res.release_event = rel;
        return lvl || press || rel;
    endfunction

    function automatic in_req_t make_sample(input int row, input int col, input bit raw,
                                            input logic [TIME_W-1:0] t);
        in_req_t smp;
        smp.key_row = ROW_W'(row);
        smp.key_column = COL_W'(col);
        smp.raw_level = raw;
        smp.now_ms = t;
        return smp;
    endfunction

    function automatic void window_row(input logic [WINDOW_W-1:0] win);
        step_t st;
        st = '{default: '0};
        st.set_win = 1'b1;
        st.win = win;
        directed_steps.push_back(st);
    endfunction

    function automatic void sample_row(input int row, input int col, input bit raw,
                                       input logic [TIME_W-1:0] t);
        step_t st;
        st = '{default: '0};
        st.smp = make_sample(row, col, raw, t);
        directed_steps.push_back(st);
    endfunction

    function automatic void pinned_row(input int row, input int col, input bit raw,
                                       input logic [TIME_W-1:0] t,
                                       input bit lvl, input bit press, input bit rel);
        step_t st;
        st = '{default: '0};
        st.smp = make_sample(row, col, raw, t);
        st.pinned = 1'b1;
        st.pin_has = lvl || press || rel;
        st.pin_res.out_row = ROW_W'(row);
        st.pin_res.out_column = COL_W'(col);
        st.pin_res.debounced_level = lvl;
        st.pin_res.press_event = press;
        st.pin_res.release_event = rel;
        directed_steps.push_back(st);
    endfunction

    // Mostly bounce sequences on a few keys, with times on the window boundary.
    function automatic in_req_t random_sample();
        in_req_t     smp;
        int unsigned k;
        if ($urandom_range(0, 3) != 0)
        begin
            k = focus_keys[$urandom_range(0, 3)];
            smp.key_row = ROW_W'(k / KEY_COLS);
            smp.key_column = COL_W'(k % KEY_COLS);
        end
        else
        begin
            smp.key_row = ROW_W'($urandom);
            smp.key_column = COL_W'($urandom);
            k = smp.key_row * KEY_COLS + smp.key_column;
        end
        smp.raw_level = ($urandom_range(0, 9) < 6) ? !key_level[k]
                                                   : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: smp.now_ms = key_start[k] + lockout_ms - 1;
            1: smp.now_ms = key_start[k] + lockout_ms;
            2: smp.now_ms = $urandom;
            default:
            begin
                scan_clock_ms = scan_clock_ms + $urandom_range(0, lockout_ms / 3 + 2);
                smp.now_ms = scan_clock_ms;
            end
        endcase
        return smp;
    endfunction

    task automatic offer_sample(input step_t st);
        out_req_t res;
        bit       has;
        @(negedge clk);
        in_valid = 1'b1;
        in_request = st.smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has = predict_debounce(st.smp, res);
        if (st.pinned)
        begin
            has = st.pin_has;
            res = st.pin_res;
        end
        if (has)
            expected_reports.push_back(res);
    endtask

    task automatic source_gap(input int cycles);
        logic [63:0] noise;
        repeat (cycles)
        begin
            @(negedge clk);
            noise = {$urandom, $urandom};
            in_valid = 1'b0;
            in_request = noise[$bits(in_req_t)-1:0];
        end
    endtask

    task automatic set_lockout(input logic [WINDOW_W-1:0] win);
        source_gap(1);
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_write_data = win;
        @(negedge clk);
        cfg_write_en = 1'b0;
        lockout_ms = win;
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            int stall_left;
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                stall_left = $urandom_range(1, 9) - 1;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                report_errors++;
                if (report_errors <= 10)
                    $display("%0t: unexpected request row %0d col %0d", $time,
                             out_request.out_row, out_request.out_column,
                             " level %0b press %0b release %0b",
                             out_request.debounced_level, out_request.press_event,
                             out_request.release_event);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_request.out_row !== want.out_row ||
                    out_request.out_column !== want.out_column ||
                    out_request.debounced_level !== want.debounced_level ||
                    out_request.press_event !== want.press_event ||
                    out_request.release_event !== want.release_event)
                begin
                    report_errors++;
                    if (report_errors <= 10)
                        $display("%0t: expected row %0d col %0d", $time,
                                 want.out_row, want.out_column,
                                 " level %0b press %0b release %0b,", want.debounced_level,
                                 want.press_event, want.release_event,
                                 " got row %0d col %0d", out_request.out_row,
                                 out_request.out_column,
                                 " level %0b press %0b release %0b",
                                 out_request.debounced_level, out_request.press_event,
                                 out_request.release_event);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        step_t               st;
        logic [WINDOW_W-1:0] win;
        int                  p;
        int                  i;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        in_request = '0;
        lockout_ms = LOCKOUT_RESET_MS;
        for (i = 0; i < KEY_COUNT; i++)
        begin
            key_level[i] = 1'b0;
            key_pending[i] = 1'b0;
            key_start[i] = '0;
        end

        // Reset window of 50 ms: window edges, time wrap and both corners of the matrix.
        pinned_row(0, 0, 1'b1, 32'd0, 1'b1, 1'b1, 1'b0);
        pinned_row(0, 0, 1'b0, 32'd10, 1'b1, 1'b0, 1'b0);
        pinned_row(0, 0, 1'b0, 32'd49, 1'b1, 1'b0, 1'b0);
        pinned_row(0, 0, 1'b0, 32'd50, 1'b0, 1'b0, 1'b1);
        pinned_row(0, 0, 1'b1, 32'd51, 1'b1, 1'b1, 1'b0);
        pinned_row(7, 15, 1'b0, 32'd77, 1'b0, 1'b0, 1'b0);
        pinned_row(7, 15, 1'b1, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0);
        pinned_row(7, 15, 1'b0, 32'h0000_0010, 1'b1, 1'b0, 1'b0);
        pinned_row(7, 15, 1'b0, 32'h0000_0022, 1'b0, 1'b0, 1'b1);
        pinned_row(7, 15, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        pinned_row(7, 15, 1'b1, 32'd0, 1'b1, 1'b0, 1'b0);
        pinned_row(5, 6, 1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0);
        sample_row(3, 9, 1'b1, 32'd123456);
        sample_row(2, 5, 1'b1, 32'h5555_5555);
        sample_row(2, 5, 1'b0, 32'h5555_5556);
        sample_row(3, 9, 1'b0, 32'd123506);
        // With no window every change is taken and a pending window closes at once.
        window_row(16'd0);
        pinned_row(1, 1, 1'b1, 32'd1000, 1'b1, 1'b1, 1'b0);
        pinned_row(1, 1, 1'b0, 32'd1000, 1'b0, 1'b0, 1'b1);
        pinned_row(1, 1, 1'b1, 32'd1000, 1'b1, 1'b1, 1'b0);
        window_row(16'hFFFF);
        pinned_row(1, 2, 1'b1, 32'd0, 1'b1, 1'b1, 1'b0);
        pinned_row(1, 2, 1'b0, 32'd65534, 1'b1, 1'b0, 1'b0);
        pinned_row(1, 2, 1'b0, 32'd65535, 1'b0, 1'b0, 1'b1);

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sink_stalls = 1'b1;
        foreach (directed_steps[j])
        begin
            if (directed_steps[j].set_win)
                set_lockout(directed_steps[j].win);
            else
                offer_sample(directed_steps[j]);
        end

        st = '{default: '0};
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: win = 16'd16;
                1: win = 16'd300;
                2: win = 16'd0;
                3: win = 16'hFFFF;
                4: win = WINDOW_W'($urandom_range(2, 65534));
                default: win = 16'd1;
            endcase
            set_lockout(win);
            for (i = 0; i < 4; i++)
                focus_keys[i] = $urandom_range(0, KEY_COUNT - 1);
            scan_clock_ms = (p == 3) ? 32'hFFFF_0000 : $urandom;
            sink_stalls = (p < 4);
            // The receiver holds off while requests keep coming, so the block backs up.
            if (p == 1)
                hold_cycles = 80;
            for (i = 0; i < PHASE_SAMPLES; i++)
            begin
                if ((p == 0 || p == 2 || p == 3) && $urandom_range(0, 4) == 0)
                    source_gap($urandom_range(1, 9));
                st.smp = random_sample();
                offer_sample(st);
            end
        end

        source_gap(1);
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (2 * SETTLE_CYCLES)
            @(negedge clk);
        if (report_errors == 0 && expected_reports.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: key_matrix_lockout_debounce.f
rtl/kmld_pkg.sv
rtl/kmld_front.sv
rtl/kmld_queue.sv
rtl/kmld_back.sv
rtl/key_matrix_lockout_debounce.sv
bench/key_matrix_lockout_debounce_tb.sv
